FILE: rtl/mwo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Morphing wavetable oscillator package
// Item codes, controller states and the fixed field widths of the oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MORPH_BITS  = 16;
  localparam int unsigned INDEX_W     = 9;
  localparam int unsigned STEP_W      = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IN_TDATA_W  = 64;

  localparam logic [MORPH_BITS-1:0] MORPH_RESET = 16'd6554;

  // Bit positions of the fields in the input tdata.
  localparam int unsigned IDX_LSB   = 0;
  localparam int unsigned VALUE_LSB = IDX_LSB + INDEX_W;
  localparam int unsigned STEP_LSB  = VALUE_LSB + SAMPLE_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_MORPH = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MORPH,
    ST_RED,
    ST_RED_SUB,
    ST_RED_FIX,
    ST_PHASE,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/mwo_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mwo_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/morphing_wavetable_oscillator.sv
`default_nettype none
// A tick item passes ST_PHASE, ST_RD_A, ST_RD_B, ST_MUL and ST_OUT, where its sample is
//   registered and it waits while a sample is unaccepted; a non-power-of-two depth adds
//   ST_RED, ST_RED_SUB and ST_RED_FIX first. A write item is taken in ST_IDLE; a morph item
//   walks the table one entry a cycle and the next item is taken once its write-backs end.
// Reset: after rst_ni a clearing pass zeroes both tables; no item is accepted until it
//   ends. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// Morphing wavetable oscillator
// Playing and snapshot tables in RAM, linear interpolation on tick items and
// a table-wide approach of playing toward snapshot on morph items.
// ----------------------------------------------------------------------------
module morphing_wavetable_oscillator
  import mwo_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH     = 512,
  parameter int unsigned PHASE_FRAC_BITS = 23
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [MORPH_BITS-1:0]  cfg_wdata_i,   // morph_fraction
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // entry_index, entry_value, phase_step
  input  wire logic [OP_W-1:0]        s_axis_tuser,  // op
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [SAMPLE_BITS-1:0] m_axis_tdata   // sample
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned F     = PHASE_FRAC_BITS;
  localparam int unsigned PHW   = AW + F;
  localparam int unsigned SUMW  = PHW + 1;
  localparam int unsigned HW    = STEP_W + 1 - F;
  localparam int unsigned DIVW  = HW + AW;
  localparam int unsigned QPW   = 2 * HW;
  localparam int unsigned IXW   = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
  localparam int unsigned MBW   = ((F > MORPH_BITS) ? F : MORPH_BITS) + 1;
  localparam int unsigned PRW   = SAMPLE_BITS + 1 + MBW;
  localparam bit          POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  localparam logic [AW-1:0]   LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [SUMW-1:0] PHASE_MOD = SUMW'(TABLE_DEPTH) << F;
  localparam logic [DIVW-1:0] DEPTH_W   = DIVW'(TABLE_DEPTH);
  localparam logic [HW-1:0]   RECIP     = HW'((64'd1 << HW) / 64'(TABLE_DEPTH));
  localparam logic signed [PRW-1:0] HALF_T = PRW'(1) << (F - 1);
  localparam logic signed [PRW-1:0] HALF_M = PRW'(1) << (MORPH_BITS - 1);

  state_e state_q, state_d;

  logic [MORPH_BITS-1:0]  morph_frac_q;
  logic [PHW-1:0]         phase_q;
  logic [HW-1:0]          rem_q;
  logic [F-1:0]           low_q;
  logic [QPW-1:0]         qprod_q;
  logic [AW-1:0]          cnt_q;
  logic                   rd_done_q;
  logic                   v1_q, v2_q;
  logic [AW-1:0]          a1_q, a2_q;
  logic [SAMPLE_BITS-1:0] base_q;
  logic signed [PRW-1:0]  prod_q;
  logic                   m_valid_q;
  logic [SAMPLE_BITS-1:0] m_data_q;

  // Input fields.
  logic                   accept;
  op_e                    in_op;
  logic [INDEX_W-1:0]     in_index;
  logic [SAMPLE_BITS-1:0] in_value;
  logic [STEP_W-1:0]      in_step;
  logic [63:0]            step_w;
  logic [IXW-1:0]         idx_ext;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_op    = op_e'(s_axis_tuser);
  assign in_index = s_axis_tdata[IDX_LSB +: INDEX_W];
  assign in_value = s_axis_tdata[VALUE_LSB +: SAMPLE_BITS];
  assign in_step  = s_axis_tdata[STEP_LSB +: STEP_W];
  assign step_w   = 64'(in_step);
  assign idx_ext  = IXW'(in_index);

  // Memory ports.
  logic                   play_we, snap_we;
  logic [AW-1:0]          play_waddr, snap_waddr, play_raddr;
  logic [SAMPLE_BITS-1:0] play_wdata, snap_wdata, play_rdata, snap_rdata;

  mwo_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TABLE_DEPTH)) u_play_ram (
    .clk_i   (clk_i),
    .we_i    (play_we),
    .waddr_i (play_waddr),
    .wdata_i (play_wdata),
    .raddr_i (play_raddr),
    .rdata_o (play_rdata)
  );

  mwo_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TABLE_DEPTH)) u_snap_ram (
    .clk_i   (clk_i),
    .we_i    (snap_we),
    .waddr_i (snap_waddr),
    .wdata_i (snap_wdata),
    .raddr_i (cnt_q),
    .rdata_o (snap_rdata)
  );

  // Phase arithmetic.
  logic [DIVW-1:0] rem_wide;
  logic [HW-1:0]   quot;
  logic [DIVW-1:0] quot_mul;
  logic [PHW-1:0]  step_red;
  logic [SUMW-1:0] phase_sum;
  logic [PHW-1:0]  phase_next;
  logic [AW-1:0]   idx, nxt;

  assign rem_wide   = DIVW'(rem_q);
  // The quotient from the reciprocal is at most one short, so one correction follows.
  assign quot       = qprod_q[QPW-1:HW];
  assign quot_mul   = DIVW'(quot) * DEPTH_W;
  // After reduction (or by masking for a power-of-two depth) the integer part is below depth.
  assign step_red   = {rem_wide[AW-1:0], low_q};
  assign phase_sum  = SUMW'(phase_q) + SUMW'(step_red);
  assign phase_next = (phase_sum >= PHASE_MOD) ? PHW'(phase_sum - PHASE_MOD) : PHW'(phase_sum);
  assign idx        = phase_q[PHW-1:F];
  assign nxt        = (idx == LAST_ADDR) ? '0 : idx + AW'(1);

  // Shared multiplier: difference times fraction, registered.
  logic                       issue;
  logic signed [SAMPLE_BITS:0] mul_a;
  logic signed [MBW-1:0]       mul_b;
  logic signed [PRW-1:0]       prod_d;
  logic signed [PRW-1:0]       rnd_t, rnd_m;
  logic [SAMPLE_BITS-1:0]      delta_t, delta_m;
  logic [SAMPLE_BITS-1:0]      sample;
  logic                        out_load;

  assign issue = (state_q == ST_MORPH) && !rd_done_q;

  always_comb begin
    if (state_q == ST_MUL) begin
      mul_a = $signed({play_rdata[SAMPLE_BITS-1], play_rdata})
            - $signed({base_q[SAMPLE_BITS-1], base_q});
      mul_b = $signed(MBW'(phase_q[F-1:0]));
    end else begin
      mul_a = $signed({snap_rdata[SAMPLE_BITS-1], snap_rdata})
            - $signed({play_rdata[SAMPLE_BITS-1], play_rdata});
      mul_b = $signed(MBW'(morph_frac_q));
    end
  end

  assign prod_d = mul_a * mul_b;

  // Rounding half up is a floor of the product plus half, so both sums shift arithmetically.
  assign rnd_t   = (prod_q + HALF_T) >>> F;
  assign rnd_m   = (prod_q + HALF_M) >>> MORPH_BITS;
  assign delta_t = rnd_t[SAMPLE_BITS-1:0];
  assign delta_m = rnd_m[SAMPLE_BITS-1:0];
  assign sample  = base_q + delta_t;

  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // Memory port selection.
  always_comb begin
    play_we    = 1'b0;
    play_waddr = a2_q;
    play_wdata = base_q + delta_m;
    snap_we    = 1'b0;
    snap_waddr = idx_ext[AW-1:0];
    snap_wdata = in_value;
    if (state_q == ST_CLEAR) begin
      play_we    = 1'b1;
      play_waddr = cnt_q;
      play_wdata = '0;
      snap_we    = 1'b1;
      snap_waddr = cnt_q;
      snap_wdata = '0;
    end else begin
      play_we = v2_q;
      snap_we = accept && (in_op == OP_WRITE) && (idx_ext < IXW'(TABLE_DEPTH));
    end
  end

  always_comb begin
    unique case (state_q)
      ST_RD_A: play_raddr = idx;
      ST_RD_B: play_raddr = nxt;
      default: play_raddr = cnt_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (in_op)
            OP_MORPH: state_d = ST_MORPH;
            OP_TICK:  state_d = POW2 ? ST_PHASE : ST_RED;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MORPH: begin
        if (rd_done_q && !v1_q && !v2_q) state_d = ST_IDLE;
      end
      ST_RED:     state_d = ST_RED_SUB;
      ST_RED_SUB: state_d = ST_RED_FIX;
      ST_RED_FIX: state_d = ST_PHASE;
      ST_PHASE:   state_d = ST_RD_A;
      ST_RD_A:    state_d = ST_RD_B;
      ST_RD_B:    state_d = ST_MUL;
      ST_MUL:     state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      morph_frac_q <= MORPH_RESET;
      phase_q      <= '0;
      cnt_q        <= '0;
      rd_done_q    <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) morph_frac_q <= cfg_wdata_i;
      if (state_q == ST_PHASE) phase_q <= phase_next;

      if (accept && (in_op == OP_MORPH)) begin
        cnt_q     <= '0;
        rd_done_q <= 1'b0;
      end else if ((state_q == ST_CLEAR) || issue) begin
        cnt_q <= cnt_q + AW'(1);
        if (issue && (cnt_q == LAST_ADDR)) rd_done_q <= 1'b1;
      end

      v1_q <= issue;
      v2_q <= v1_q;

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept && (in_op == OP_TICK)) begin
      rem_q <= HW'(step_w >> F);
      low_q <= step_w[F-1:0];
    end else if (state_q == ST_RED_SUB) begin
      rem_q <= HW'(rem_wide - quot_mul);
    end else if ((state_q == ST_RED_FIX) && (rem_wide >= DEPTH_W)) begin
      rem_q <= HW'(rem_wide - DEPTH_W);
    end
    // The integer part of the step is reduced modulo the depth by a reciprocal multiply.
    if (state_q == ST_RED) qprod_q <= QPW'(rem_q) * QPW'(RECIP);
    a1_q <= cnt_q;
    a2_q <= a1_q;
    if ((state_q == ST_RD_B) || v1_q) base_q <= play_rdata;
    if ((state_q == ST_MUL) || v1_q) prod_q <= prod_d;
    if (out_load) m_data_q <= sample;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUMW'(phase_q) < PHASE_MOD)
    else $error("phase accumulator left its range");

  a_morph_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && v2_q) |-> (cnt_q != a2_q))
    else $error("morph read and write-back hit the same entry");

  a_out_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result shown without a finished tick");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q || (state_q == ST_CLEAR)) |-> !s_axis_tready)
    else $error("input taken while a table walk is in progress");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morphing wavetable oscillator testbench
// Sends write, morph, tick and unused items over the input stream and keeps
// its own copy of both tables and the phase. Every sample that leaves the
// block is compared with the oldest predicted sample. Both stream sides idle
// at random in paced runs, and the morph fraction is changed between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import mwo_pkg::*;

  localparam int unsigned DEPTH     = 512;
  localparam int unsigned FRAC_BITS = 23;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [MORPH_BITS-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [SAMPLE_BITS-1:0] m_axis_tdata;

  morphing_wavetable_oscillator #(
    .TABLE_DEPTH     (DEPTH),
    .PHASE_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predicted state of the oscillator.
  logic [SAMPLE_BITS-1:0] play_tab [DEPTH];
  logic [SAMPLE_BITS-1:0] snap_tab [DEPTH];
  logic [STEP_W-1:0]      phase_acc;
  logic [MORPH_BITS-1:0]  morph_frac;

  logic [SAMPLE_BITS-1:0] pending_samples [$];
  logic [SAMPLE_BITS-1:0] want_sample;
  int unsigned            fault_count;
  int unsigned            quiet_cycles;
  bit                     pace_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Rounded convex combination of two signed samples with weight w / 2^shift.
  // Flipping the sign bit offsets a sample by half its range.
  function automatic logic [SAMPLE_BITS-1:0] weighted_mix(logic [SAMPLE_BITS-1:0] a,
                                                          logic [SAMPLE_BITS-1:0] b,
                                                          longint unsigned w,
                                                          int unsigned shift);
    longint unsigned ua, ub, one, acc;
    ua  = {48'd0, a ^ 16'h8000};
    ub  = {48'd0, b ^ 16'h8000};
    one = 64'd1 << shift;
    acc = (ua * (one - w) + ub * w + (one >> 1)) >> shift;
    return acc[SAMPLE_BITS-1:0] ^ 16'h8000;
  endfunction

  function automatic void advance_oscillator(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                             logic [SAMPLE_BITS-1:0] val,
                                             logic [STEP_W-1:0] step);
    logic [INDEX_W-1:0]   here, next_entry;
    logic [FRAC_BITS-1:0] frac;
    case (op)
      OP_WRITE: begin
        if (idx < DEPTH) snap_tab[idx] = val;
      end
      OP_MORPH: begin
        for (int k = 0; k < DEPTH; k++)
          play_tab[k] = weighted_mix(play_tab[k], snap_tab[k], morph_frac, 16);
      end
      OP_TICK: begin
        // The phase range is exactly 2^32 here, so the wrap is the natural one.
        phase_acc  = phase_acc + step;
        here       = phase_acc[STEP_W-1:FRAC_BITS];
        frac       = phase_acc[FRAC_BITS-1:0];
        next_entry = here + 1'b1;
        pending_samples.push_back(weighted_mix(play_tab[here], play_tab[next_entry],
                                               frac, FRAC_BITS));
      end
      default: ;
    endcase
  endfunction

  function automatic void note_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", what);
  endfunction

  // Sender: called just after a rising edge, returns just after the accepting edge.
  task automatic send_item(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                           logic [SAMPLE_BITS-1:0] val, logic [STEP_W-1:0] step);
    if (pace_on) begin
      while ($urandom_range(99) < 33) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W-STEP_LSB-STEP_W){1'b0}}, step, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_oscillator(op, idx, val, step);
  endtask

  // Stops sending, waits for every predicted sample, then lets the block settle.
  task automatic wait_idle(int unsigned settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_morph_fraction(logic [MORPH_BITS-1:0] frac);
    // A morph item gives no sample, so it may still be walking the table.
    wait_idle(DEPTH + 8);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= frac;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    morph_frac  = frac;
  endtask

  // Output side: random back-pressure and the comparison of every sample.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        note_fault($sformatf("sample %0d with none expected", $signed(m_axis_tdata)));
      end else begin
        want_sample = pending_samples.pop_front();
        if (m_axis_tdata !== want_sample)
          note_fault($sformatf("sample expected %0d, got %0d",
                               $signed(want_sample), $signed(m_axis_tdata)));
      end
    end
    m_axis_tready <= pace_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Both tables are zero after reset, so every tick must give silence.
  task automatic test_silent_tables();
    send_item(OP_TICK, '0, '0, 32'd0);
    send_item(OP_TICK, '1, '1, 32'h0123_4567);
  endtask

  task automatic test_table_edges();
    send_item(OP_WRITE, 9'd0,   16'h7FFF, '0);
    send_item(OP_WRITE, 9'd511, 16'h8000, '1);
    send_item(OP_WRITE, 9'd1,   16'hFFFF, '0);
    send_item(OP_UNUSED, '1, '1, '1);
    send_item(OP_MORPH, '0, '0, '0);
    send_item(OP_TICK, '0, '0, 32'd0);
    // A step of all ones wraps the phase round and leaves it one unit lower.
    send_item(OP_TICK, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_TICK, '0, '0, 32'h0040_0000);
    send_item(OP_TICK, '0, '0, 32'h0080_0000);
  endtask

  task automatic test_fraction_extremes();
    set_morph_fraction(16'hFFFF);
    send_item(OP_MORPH, '1, '1, '1);
    send_item(OP_TICK, '0, '0, 32'h7FC0_0000);
    send_item(OP_TICK, '0, '0, 32'h8000_0000);
    send_item(OP_TICK, '0, '0, 32'hFFFF_FFFF);
    set_morph_fraction(16'h0000);
    send_item(OP_WRITE, 9'd255, 16'h5555, '0);
    send_item(OP_MORPH, '0, '0, '0);
    send_item(OP_TICK, '0, '0, 32'h0000_0001);
  endtask

  task automatic test_random_traffic(int unsigned n_items, logic [MORPH_BITS-1:0] frac,
                                     bit paced, bit pause_midway);
    int unsigned            sent, roll;
    logic [OP_W-1:0]        op;
    logic [STEP_W-1:0]      step;
    set_morph_fraction(frac);
    pace_on = paced;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 40)      op = OP_WRITE;
      else if (roll < 45) op = OP_MORPH;
      else if (roll < 95) op = OP_TICK;
      else                op = OP_UNUSED;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: step = $urandom_range(32'h00FF_FFFF);
        5, 6, 7:       step = $urandom;
        default:       step = {9'($urandom_range(DEPTH - 1)), 23'd0};
      endcase
      send_item(op, 9'($urandom_range(DEPTH - 1)), 16'($urandom), step);
      if (op != OP_UNUSED) sent++;
      if (pause_midway && sent == n_items / 2) wait_idle(0);
    end
    pace_on = 1'b1;
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      play_tab[k] = '0;
      snap_tab[k] = '0;
    end
    phase_acc     = '0;
    morph_frac    = MORPH_RESET;
    fault_count   = 0;
    quiet_cycles  = 0;
    pace_on       = 1'b1;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_WRITE;
    m_axis_tready <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_silent_tables();
    test_table_edges();
    test_fraction_extremes();
    test_random_traffic(127, 16'($urandom_range(1, 65534)), 1'b1, 1'b1);
    test_random_traffic(127, 16'hFFFF, 1'b0, 1'b0);
    test_random_traffic(127, 16'h0000, 1'b1, 1'b0);
    test_random_traffic(127, 16'h8000, 1'b1, 1'b1);

    wait_idle(DEPTH + 16);
    if (fault_count == 0 && pending_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
